### rtl/assert_macros.svh
// Assertion macros shared by the class priority queue RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, suppressed while reset is high.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cpq_pkg.sv
// Package of the class priority queue: field widths, codes and the
// controller/datapath command and status types. No dependencies.
package cpq_pkg;

   localparam int DEPTH_DEFAULT   = 64;
   localparam int ID_BITS_DEFAULT = 16;

   localparam int ITEM_ID_W = 16;
   localparam int CLASS_W   = 2;
   localparam int AGE_W     = 7;

   // Operation codes of a request.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // The only class in which entries are ordered by age.
   localparam logic [CLASS_W-1:0] CLASS_AGE_ORDERED = 2'd2;

   typedef struct packed {
      logic capture;   // latch the request and the per-cell compare flags
      logic apply;     // update the cells and load the result register
   } cpq_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_busy;  // result register holds a transaction not taken this cycle
   } cpq_status_type;

endpackage

### rtl/cpq_if.sv
// Request and response channel interfaces of the class priority queue.
// Depends on cpq_pkg for the field widths.
interface cpq_req_if import cpq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [CLASS_W-1:0]   prio_class;
   logic [AGE_W-1:0]     age;
   logic [ITEM_ID_W-1:0] item_id;

   modport source (output valid, op, prio_class, age, item_id, input ready);
   modport sink   (input valid, op, prio_class, age, item_id, output ready);
endinterface

interface cpq_rsp_if import cpq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ITEM_ID_W-1:0] out_id;
   logic [CLASS_W-1:0]   out_class;
   logic [AGE_W-1:0]     out_age;
   logic                 out_valid;
   logic                 was_empty;
   logic                 was_full;

   modport source (output valid, out_id, out_class, out_age, out_valid, was_empty,
                   was_full, input ready);
   modport sink   (input valid, out_id, out_class, out_age, out_valid, was_empty,
                   was_full, output ready);
endinterface

### rtl/cpq_ctrl.sv
// Controller of the class priority queue: sequences capture and apply.
// Depends on cpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpq_ctrl import cpq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cpq_status_type status,
   output cpq_cmd_type    cmd,
   output logic           req_ready
);

   typedef enum logic {
      S_IDLE,
      S_APPLY
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (status.req_valid) state_in = S_APPLY;
         end
         S_APPLY: begin
            // Wait until the result register can take the new transaction.
            if (!status.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && status.req_valid;
   assign cmd.apply   = (state_ff == S_APPLY) && !status.rsp_busy;

   `ASSERT_CLK(a_capture_then_apply, clock, reset, cmd.capture |=> state_ff == S_APPLY, "capture not followed by apply state")
   `ASSERT_CLK(a_apply_needs_room, clock, reset, cmd.apply |-> !status.rsp_busy, "apply while result register busy")
   `ASSERT_CLK(a_apply_ends_item, clock, reset, cmd.apply |=> req_ready, "not ready after apply")

endmodule

### rtl/cpq_datapath.sv
// Datapath of the class priority queue: request register, sorted shift-insert
// cell chain and result register. Depends on cpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpq_datapath import cpq_pkg::*; #(
   parameter int DEPTH   = DEPTH_DEFAULT,
   parameter int ID_BITS = ID_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cpq_cmd_type          cmd,
   output logic                 rsp_busy,
   input  logic                 req_op,
   input  logic [CLASS_W-1:0]   req_class,
   input  logic [AGE_W-1:0]     req_age,
   input  logic [ITEM_ID_W-1:0] req_item_id,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ITEM_ID_W-1:0] rsp_out_id,
   output logic [CLASS_W-1:0]   rsp_out_class,
   output logic [AGE_W-1:0]     rsp_out_age,
   output logic                 rsp_out_valid,
   output logic                 rsp_was_empty,
   output logic                 rsp_was_full
);

   // Request register.
   logic               op_ff;
   logic [CLASS_W-1:0] cls_ff;
   logic [AGE_W-1:0]   age_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [31:0]        id_wide;

   // Cell chain, head at cell 0. Valid cells always form a prefix.
   logic [ID_BITS-1:0] cell_id_ff  [DEPTH];
   logic [CLASS_W-1:0] cell_cls_ff [DEPTH];
   logic [AGE_W-1:0]   cell_age_ff [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [DEPTH-1:0]   valid_in;
   logic [DEPTH-1:0]   before_ff;
   logic [DEPTH-1:0]   before_in;

   logic full;
   logic empty;
   logic do_push;
   logic do_pop;

   // Result register.
   logic                 rsp_valid_ff;
   logic [ITEM_ID_W-1:0] out_id_ff;
   logic [CLASS_W-1:0]   out_cls_ff;
   logic [AGE_W-1:0]     out_age_ff;
   logic                 out_valid_ff;
   logic                 was_empty_ff;
   logic                 was_full_ff;
   logic [31:0]          head_id_wide;

   assign id_wide      = {{(32 - ITEM_ID_W){1'b0}}, req_item_id};
   assign head_id_wide = 32'(cell_id_ff[0]);

   assign full    = valid_ff[DEPTH-1];
   assign empty   = !valid_ff[0];
   assign do_push = cmd.apply && (op_ff == OP_PUSH) && !full;
   assign do_pop  = cmd.apply && (op_ff == OP_POP) && !empty;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         cls_ff    <= req_class;
         age_ff    <= req_age;
         id_ff     <= id_wide[ID_BITS-1:0];
         before_ff <= before_in;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic from_prev;

         // The new entry goes in front of an empty cell, a lower class, or an
         // younger entry of the age-ordered class. Along the sorted chain the
         // flags read false up to the insertion point and true after it.
         assign before_in[gi] = !valid_ff[gi] || (cell_cls_ff[gi] < req_class) ||
                                ((req_class == CLASS_AGE_ORDERED) &&
                                 (cell_cls_ff[gi] == CLASS_AGE_ORDERED) &&
                                 (cell_age_ff[gi] < req_age));

         if (gi == 0) begin : g_head
            assign from_prev = 1'b0;
         end else begin : g_body
            assign from_prev = before_ff[gi-1];
         end

         always_comb begin
            valid_in[gi] = valid_ff[gi];
            if (do_push) begin
               if (from_prev) begin
                  valid_in[gi] = (gi == 0) ? 1'b0 : valid_ff[(gi == 0) ? 0 : gi-1];
               end else if (before_ff[gi]) begin
                  valid_in[gi] = 1'b1;
               end
            end else if (do_pop) begin
               valid_in[gi] = (gi == DEPTH-1) ? 1'b0 : valid_ff[(gi == DEPTH-1) ? gi : gi+1];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[gi] <= 1'b0;
            end else begin
               valid_ff[gi] <= valid_in[gi];
            end
         end

         if (gi == 0) begin : g_head_data
            always_ff @(posedge clock) begin
               if (do_push && before_ff[gi]) begin
                  cell_id_ff[gi]  <= id_ff;
                  cell_cls_ff[gi] <= cls_ff;
                  cell_age_ff[gi] <= age_ff;
               end else if (do_pop && DEPTH > 1) begin
                  cell_id_ff[gi]  <= cell_id_ff[gi+1];
                  cell_cls_ff[gi] <= cell_cls_ff[gi+1];
                  cell_age_ff[gi] <= cell_age_ff[gi+1];
               end
            end
         end else if (gi == DEPTH-1) begin : g_tail_data
            always_ff @(posedge clock) begin
               if (do_push && from_prev) begin
                  cell_id_ff[gi]  <= cell_id_ff[gi-1];
                  cell_cls_ff[gi] <= cell_cls_ff[gi-1];
                  cell_age_ff[gi] <= cell_age_ff[gi-1];
               end else if (do_push && before_ff[gi]) begin
                  cell_id_ff[gi]  <= id_ff;
                  cell_cls_ff[gi] <= cls_ff;
                  cell_age_ff[gi] <= age_ff;
               end
            end
         end else begin : g_mid_data
            always_ff @(posedge clock) begin
               if (do_push && from_prev) begin
                  cell_id_ff[gi]  <= cell_id_ff[gi-1];
                  cell_cls_ff[gi] <= cell_cls_ff[gi-1];
                  cell_age_ff[gi] <= cell_age_ff[gi-1];
               end else if (do_push && before_ff[gi]) begin
                  cell_id_ff[gi]  <= id_ff;
                  cell_cls_ff[gi] <= cls_ff;
                  cell_age_ff[gi] <= age_ff;
               end else if (do_pop) begin
                  cell_id_ff[gi]  <= cell_id_ff[gi+1];
                  cell_cls_ff[gi] <= cell_cls_ff[gi+1];
                  cell_age_ff[gi] <= cell_age_ff[gi+1];
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         out_id_ff    <= do_pop ? head_id_wide[ITEM_ID_W-1:0] : '0;
         out_cls_ff   <= do_pop ? cell_cls_ff[0] : '0;
         out_age_ff   <= do_pop ? cell_age_ff[0] : '0;
         out_valid_ff <= do_pop;
         was_empty_ff <= (op_ff == OP_POP) && empty;
         was_full_ff  <= (op_ff == OP_PUSH) && full;
      end
   end

   assign rsp_busy      = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_id    = out_id_ff;
   assign rsp_out_class = out_cls_ff;
   assign rsp_out_age   = out_age_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_was_empty = was_empty_ff;
   assign rsp_was_full  = was_full_ff;

   `ASSERT_CLK(a_push_adds_one, clock, reset, do_push |=> $countones(valid_ff) == $past($countones(valid_ff)) + 1, "push did not add exactly one entry")
   `ASSERT_CLK(a_pop_removes_one, clock, reset, do_pop |=> $countones(valid_ff) + 1 == $past($countones(valid_ff)), "pop did not remove exactly one entry")
   `ASSERT_CLK(a_one_outcome, clock, reset, rsp_valid_ff |-> $onehot0({out_valid_ff, was_empty_ff, was_full_ff}), "result carries more than one outcome")

endmodule

### rtl/class_priority_queue.sv
// Top level of the class priority queue: controller plus datapath.
// Depends on cpq_pkg, cpq_if, cpq_ctrl and cpq_datapath.
//
// A queue of up to DEPTH entries held in a chain of cells, sorted with the
// highest class at the head and first in first out within a class; in class 2
// an older entry goes ahead of younger ones. Every request transaction (push
// or pop) yields exactly one response transaction. At acceptance every cell
// compares itself with the new entry in parallel; in the apply step that
// follows, all cells shift in one step and the result register is loaded,
// and only then is a new request accepted. The apply step waits while the
// result register holds a response not yet taken. A push to a full queue is
// dropped and answered with was_full; a pop of an empty queue is answered
// with was_empty. No clearing pass is needed after reset.
module class_priority_queue import cpq_pkg::*; #(
   parameter int DEPTH   = DEPTH_DEFAULT,
   parameter int ID_BITS = ID_BITS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   cpq_req_if.sink  req_chan,
   cpq_rsp_if.source rsp_chan
);

   cpq_cmd_type    cmd;
   cpq_status_type status;
   logic           rsp_busy;

   assign status.req_valid = req_chan.valid;
   assign status.rsp_busy  = rsp_busy;

   cpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_chan.ready)
   );

   cpq_datapath #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .rsp_busy      (rsp_busy),
      .req_op        (req_chan.op),
      .req_class     (req_chan.prio_class),
      .req_age       (req_chan.age),
      .req_item_id   (req_chan.item_id),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_out_id    (rsp_chan.out_id),
      .rsp_out_class (rsp_chan.out_class),
      .rsp_out_age   (rsp_chan.out_age),
      .rsp_out_valid (rsp_chan.out_valid),
      .rsp_was_empty (rsp_chan.was_empty),
      .rsp_was_full  (rsp_chan.was_full)
   );

endmodule
